// ===== src/rgb_to_hsv_converter_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RHC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
// Implication on the following clock edge.
`define RHC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

// ===== src/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
package rhc_pkg;
    localparam int NumCells = 8;          // one quotient bit per cell
    localparam int Lat = NumCells + 2;    // request to result latency
    localparam logic [8:0] HueSector = 9'd60;
    localparam logic [8:0] HueGreen = 9'd120;
    localparam logic [8:0] HueBlue = 9'd240;
    localparam logic [8:0] HueTurn = 9'd360;

    // One restoring-divider operand set that moves down the row.
    typedef struct packed {
        logic        vld;
        logic [13:0] hrem;   // hue remainder / dividend
        logic [7:0]  hdiv;   // chroma
        logic [5:0]  hq;     // hue quotient bits
        logic        hneg;
        logic [8:0]  hbase;
        logic [15:0] srem;
        logic [7:0]  sdiv;   // max
        logic [7:0]  sq;
        logic        zero;
        logic [7:0]  vmax;
    } t_cell;
endpackage

// ===== src/rhc_cell.sv =====
// One divider cell: one quotient bit of saturation per cycle, and of hue for bits 5..0.
module rhc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rhc_pkg::t_cell i_d,
    input  logic [3:0]     i_bit,
    output rhc_pkg::t_cell o_d
);
    import rhc_pkg::*;
    t_cell n_d, r_d;
    logic [13:0] hsh;
    logic [15:0] ssh;
    always_comb begin
        n_d = i_d;
        hsh = {6'd0, i_d.hdiv} << i_bit;
        ssh = {8'd0, i_d.sdiv} << i_bit;
        if (i_bit < 4'd6) begin
            if (i_d.hrem >= hsh) begin
                n_d.hrem = i_d.hrem - hsh;
                n_d.hq = i_d.hq | (6'd1 << i_bit[2:0]);
            end
        end
        if (i_d.srem >= ssh) begin
            n_d.srem = i_d.srem - ssh;
            n_d.sq = i_d.sq | (8'd1 << i_bit[2:0]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d.vld <= 1'b0;
        else r_d.vld <= n_d.vld;
        {r_d.hrem, r_d.hdiv, r_d.hq, r_d.hneg, r_d.hbase, r_d.srem, r_d.sdiv, r_d.sq,
         r_d.zero, r_d.vmax} <= {n_d.hrem, n_d.hdiv, n_d.hq, n_d.hneg, n_d.hbase,
         n_d.srem, n_d.sdiv, n_d.sq, n_d.zero, n_d.vmax};
    end
    assign o_d = r_d;
endmodule

// ===== src/rgb_to_hsv_converter_core.sv =====
// Top level of the RGB to HSV converter: front end, divider cell row, finish stage.
//  channel | dir | ports                              | handshake
//  request | in  | i_red i_green i_blue               | start while busy low
//  result  | out | o_hue o_saturation o_brightness    | o_done, one cycle
// One request per cycle; each result passes the front-end register, the row of
// eight divider cells, one quotient bit each, and the result register.
// busy is always low: the row never stalls and the receiver cannot stall.
// Reset clears only the valid flags along the row and o_done.
module rgb_to_hsv_converter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_done,
    output logic [8:0] o_hue,
    output logic [7:0] o_saturation,
    output logic [7:0] o_brightness
);
    import rhc_pkg::*;
    t_cell n_f, r_f;
    t_cell row [NumCells+1];
    logic [7:0] hi, lo, a, b;
    logic [8:0] base, hq9, hue_n;
    logic neg;

    assign busy = 1'b0;

    // Front end: find max/min, pick the sector and form both dividends.
    always_comb begin
        hi = i_red; lo = i_red;
        if (i_green > hi) hi = i_green;
        if (i_blue > hi) hi = i_blue;
        if (i_green < lo) lo = i_green;
        if (i_blue < lo) lo = i_blue;
        if (i_red == hi) begin a = i_green; b = i_blue; base = 9'd0; end
        else if (i_green == hi) begin a = i_blue; b = i_red; base = HueGreen; end
        else begin a = i_red; b = i_green; base = HueBlue; end
        neg = a < b;
        n_f.vld = start;
        n_f.hrem = 14'(HueSector) * 14'(neg ? (b - a) : (a - b));
        n_f.hdiv = hi - lo;
        n_f.hq = '0;
        n_f.hneg = neg;
        n_f.hbase = base;
        n_f.srem = 16'd255 * 16'(hi - lo);
        n_f.sdiv = hi;
        n_f.sq = '0;
        n_f.zero = (hi == lo);
        n_f.vmax = hi;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f.vld <= 1'b0;
        else r_f.vld <= n_f.vld;
        {r_f.hrem, r_f.hdiv, r_f.hq, r_f.hneg, r_f.hbase, r_f.srem, r_f.sdiv, r_f.sq,
         r_f.zero, r_f.vmax} <= {n_f.hrem, n_f.hdiv, n_f.hq, n_f.hneg, n_f.hbase,
         n_f.srem, n_f.sdiv, n_f.sq, n_f.zero, n_f.vmax};
    end
    assign row[0] = r_f;

    // Divider row: cell k resolves quotient bit NumCells-1-k.
    for (genvar k = 0; k < NumCells; k++) begin : g_cell
        rhc_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_d(row[k]),
            .i_bit(4'(NumCells - 1 - k)), .o_d(row[k+1])
        );
    end

    // Finish: apply sign, sector offset and wrap, zero hue and saturation when max equals min, then register.
    always_comb begin
        hq9 = {3'd0, row[NumCells].hq};
        hue_n = row[NumCells].hneg ? (row[NumCells].hbase - hq9)
                                   : (row[NumCells].hbase + hq9);
        if (row[NumCells].hneg && (hq9 > row[NumCells].hbase)) hue_n = hue_n + HueTurn;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else o_done <= row[NumCells].vld;
        o_hue <= row[NumCells].zero ? 9'd0 : hue_n;
        o_saturation <= row[NumCells].zero ? 8'd0 : row[NumCells].sq;
        o_brightness <= row[NumCells].vmax;
    end
endmodule

// ===== src/rhc_checker.sv =====
// Port-level checker for the RGB to HSV converter, bound to the top level.
`include "rgb_to_hsv_converter_core_defines.svh"
module rhc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [8:0] o_hue,
    input logic [7:0] o_saturation,
    input logic [7:0] o_brightness
);
    import rhc_pkg::*;
    `RHC_ASSERT_IMP(a_hue_range, i_clk, i_rst_n, o_done, o_hue < HueTurn)
    `RHC_ASSERT_IMP(a_black, i_clk, i_rst_n, o_done && o_brightness == 8'd0,
        o_hue == 9'd0 && o_saturation == 8'd0)
    `RHC_ASSERT_IMP(a_latency, i_clk, i_rst_n, $past(start && !busy, Lat), o_done)
    `RHC_ASSERT_NXT(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (.*);
